// File: rtl/signed_integer_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII block.
// Assertions are compiled in unless ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside reset.
`define SITDA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define SITDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SITDA_ASSERT(lbl, clk, rstn, prop, msg)
`define SITDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and types of the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_W        = 64;
	localparam int MAX_DIGITS_DEF = 20;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Shift-and-add-3 correction: a digit of five or more gets three added
	// before it is doubled, so that it carries into the next decade.
	localparam logic [3:0] ADJ_THRESH = 4'd5;
	localparam logic [3:0] ADJ_ADD    = 4'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_DIGIT,
		ST_SPACE
	} state_t;

	typedef enum logic [1:0] {
		DAB_HOLD,
		DAB_LOAD,
		DAB_STEP,
		DAB_SHIFT
	} dab_op_t;

	typedef struct packed {
		dab_op_t op;
	} dab_ctl_t;

	typedef struct packed {
		logic       last_bit;
		logic       overflow;
		logic [3:0] top_digit;
	} dab_sts_t;

endpackage

// File: rtl/sitda_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for the number requests and the character results.
// ----------------------------------------------------------------------------
interface sitda_num_if;
	logic                                valid;
	logic                                ready;
	logic signed [sitda_pkg::VALUE_W-1:0] value;
	logic                                add_space;

	modport source (output valid, output value, output add_space, input ready);
	modport sink (input valid, input value, input add_space, output ready);
endinterface

interface sitda_txt_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/sitda_dabble.sv
// ----------------------------------------------------------------------------
// sitda_dabble
// Bit-serial binary to BCD converter with a digit register that shifts out
// one decimal digit at a time, most significant first.
// ----------------------------------------------------------------------------
module sitda_dabble #(
	parameter int MAX_DIGITS = sitda_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sitda_pkg::dab_ctl_t             ctl,
	input  logic [sitda_pkg::VALUE_W-1:0]   magnitude,
	output sitda_pkg::dab_sts_t             sts
);

	localparam int BitW = $clog2(sitda_pkg::VALUE_W);

	logic [sitda_pkg::VALUE_W-1:0] mag_q;
	logic [BitW-1:0]               bit_cnt_q;
	logic                          ovf_q;
	logic [3:0]                    bcd_q [MAX_DIGITS];
	logic [3:0]                    adj   [MAX_DIGITS];
	logic [3:0]                    dbl   [MAX_DIGITS];

	// Correct every digit in parallel, then double the whole decimal word
	// and bring in the next magnitude bit at the bottom.
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= sitda_pkg::ADJ_THRESH) ?
				bcd_q[i] + sitda_pkg::ADJ_ADD : bcd_q[i];
		end
		dbl[0] = {adj[0][2:0], mag_q[sitda_pkg::VALUE_W-1]};
		for (int i = 1; i < MAX_DIGITS; i++) begin
			dbl[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			sitda_pkg::DAB_LOAD: begin
				mag_q <= magnitude;
				for (int i = 0; i < MAX_DIGITS; i++) bcd_q[i] <= '0;
			end
			sitda_pkg::DAB_STEP: begin
				mag_q <= {mag_q[sitda_pkg::VALUE_W-2:0], 1'b0};
				for (int i = 0; i < MAX_DIGITS; i++) bcd_q[i] <= dbl[i];
			end
			sitda_pkg::DAB_SHIFT: begin
				bcd_q[0] <= '0;
				for (int i = 1; i < MAX_DIGITS; i++) bcd_q[i] <= bcd_q[i-1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			case (ctl.op)
				sitda_pkg::DAB_LOAD: begin
					bit_cnt_q <= '0;
					ovf_q     <= 1'b0;
				end
				sitda_pkg::DAB_STEP: begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
					// A bit carried out of the top digit means the number has
					// more digits than the register holds.
					ovf_q     <= ovf_q | adj[MAX_DIGITS-1][3];
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.last_bit  = (ctl.op == sitda_pkg::DAB_STEP) &&
		(bit_cnt_q == BitW'(sitda_pkg::VALUE_W - 1));
	assign sts.overflow  = ovf_q;
	assign sts.top_digit = bcd_q[MAX_DIGITS-1];

endmodule

// File: rtl/signed_integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_integer_to_decimal_ascii
// Prints a signed 64-bit integer as decimal ASCII text, one character per
// result.
// ----------------------------------------------------------------------------
// Each number request yields a '-' when the value is negative, the decimal
// digits of its exact magnitude, most significant first (zero prints as a
// single '0', and the most negative value prints in full), and a trailing
// space when add_space is set; last_char marks the final character. At
// most MAX_DIGITS digits are kept: a longer magnitude is printed modulo
// 10^MAX_DIGITS with all MAX_DIGITS places shown. Steps per request: it is
// accepted, converted by shift-and-add-3 (one magnitude bit per cycle
// through the per-digit correction logic), the leading zero places are
// skipped (up to MAX_DIGITS - 1 of them) and the first printed place is
// found, then the characters are emitted while the output is being taken.
// The block takes a new request only after the last character of the
// previous one has entered the output register; that character may still be
// waiting there when the next request is accepted.
// ----------------------------------------------------------------------------
`include "signed_integer_to_decimal_ascii_defines.svh"

module signed_integer_to_decimal_ascii #(
	parameter int MAX_DIGITS = sitda_pkg::MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sitda_num_if.sink   num,
	sitda_txt_if.source txt
);

	localparam int CntW = $clog2(MAX_DIGITS + 1);

	sitda_pkg::state_t   state_q;
	sitda_pkg::state_t   state_d;
	sitda_pkg::dab_ctl_t dab_ctl;
	sitda_pkg::dab_sts_t dab_sts;

	logic                          neg_q;
	logic                          space_q;
	logic [CntW-1:0]               cnt_q;
	logic [sitda_pkg::VALUE_W-1:0] magnitude;

	logic       txt_valid_q;
	logic [7:0] txt_char_q;
	logic       txt_last_q;

	logic       accept;
	logic       emit_ok;
	logic       skip_zero;
	logic       cnt_dec;
	logic       emit_vld;
	logic [7:0] emit_char;
	logic       emit_last;

	// The output slot is free when it is empty or its character leaves now.
	assign emit_ok = !txt_valid_q || txt.ready;
	assign accept  = num.valid && num.ready;

	// Two's complement negation in unsigned arithmetic is exact, also for
	// the most negative value.
	assign magnitude = num.value[sitda_pkg::VALUE_W-1] ?
		(~num.value + 1'b1) : num.value;

	// A leading zero place is dropped unless it is the only digit left or
	// the number overflowed the register, in which case every place prints.
	assign skip_zero = (dab_sts.top_digit == 4'd0) && !dab_sts.overflow &&
		(cnt_q > CntW'(1));

	sitda_dabble #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dab_ctl),
		.magnitude(magnitude),
		.sts      (dab_sts)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (num.valid) state_d = sitda_pkg::ST_CONV;
			end
			sitda_pkg::ST_CONV: begin
				if (dab_sts.last_bit) begin
					state_d = neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_SKIP;
				end
			end
			sitda_pkg::ST_SIGN: begin
				if (emit_ok) state_d = sitda_pkg::ST_SKIP;
			end
			sitda_pkg::ST_SKIP: begin
				if (!skip_zero) state_d = sitda_pkg::ST_DIGIT;
			end
			sitda_pkg::ST_DIGIT: begin
				if (emit_ok && (cnt_q == CntW'(1))) begin
					state_d = space_q ? sitda_pkg::ST_SPACE : sitda_pkg::ST_IDLE;
				end
			end
			sitda_pkg::ST_SPACE: begin
				if (emit_ok) state_d = sitda_pkg::ST_IDLE;
			end
			default: begin
				state_d = sitda_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		num.ready  = 1'b0;
		dab_ctl.op = sitda_pkg::DAB_HOLD;
		cnt_dec    = 1'b0;
		emit_vld   = 1'b0;
		emit_char  = sitda_pkg::CH_ZERO;
		emit_last  = 1'b0;
		case (state_q)
			sitda_pkg::ST_IDLE: begin
				num.ready = 1'b1;
				if (num.valid) dab_ctl.op = sitda_pkg::DAB_LOAD;
			end
			sitda_pkg::ST_CONV: begin
				dab_ctl.op = sitda_pkg::DAB_STEP;
			end
			sitda_pkg::ST_SIGN: begin
				emit_vld  = emit_ok;
				emit_char = sitda_pkg::CH_MINUS;
			end
			sitda_pkg::ST_SKIP: begin
				if (skip_zero) begin
					dab_ctl.op = sitda_pkg::DAB_SHIFT;
					cnt_dec    = 1'b1;
				end
			end
			sitda_pkg::ST_DIGIT: begin
				if (emit_ok) begin
					dab_ctl.op = sitda_pkg::DAB_SHIFT;
					cnt_dec    = 1'b1;
				end
				emit_vld  = emit_ok;
				emit_char = sitda_pkg::CH_ZERO + {4'd0, dab_sts.top_digit};
				emit_last = (cnt_q == CntW'(1)) && !space_q;
			end
			sitda_pkg::ST_SPACE: begin
				emit_vld  = emit_ok;
				emit_char = sitda_pkg::CH_SPACE;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sitda_pkg::ST_IDLE;
			cnt_q       <= '0;
			txt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= CntW'(MAX_DIGITS);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (emit_vld) begin
				txt_valid_q <= 1'b1;
			end else if (txt.ready) begin
				txt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= num.value[sitda_pkg::VALUE_W-1];
			space_q <= num.add_space;
		end
		if (emit_vld) begin
			txt_char_q <= emit_char;
			txt_last_q <= emit_last;
		end
	end

	assign txt.valid     = txt_valid_q;
	assign txt.char_code = txt_char_q;
	assign txt.last_char = txt_last_q;

	// An accepted request always starts the conversion pass.
	`SITDA_ASSERT_NEXT(a_accept_starts_conv, clk, arst_n, accept,
		state_q == sitda_pkg::ST_CONV, "accepted request did not start conversion")

	// The conversion pass ends in the sign or the zero-skip phase.
	`SITDA_ASSERT_NEXT(a_conv_exit, clk, arst_n,
		(state_q == sitda_pkg::ST_CONV) && dab_sts.last_bit,
		(state_q == sitda_pkg::ST_SIGN) || (state_q == sitda_pkg::ST_SKIP),
		"conversion ended in the wrong phase")

	// Digits are printed only while some remain.
	`SITDA_ASSERT(a_digit_cnt, clk, arst_n,
		((state_q == sitda_pkg::ST_DIGIT) || (state_q == sitda_pkg::ST_SKIP)) |->
		(cnt_q != '0), "digit phase with no digits left")

	// A pending character holds steady until the receiver takes it.
	`SITDA_ASSERT_NEXT(a_txt_hold, clk, arst_n, txt_valid_q && !txt.ready,
		txt_valid_q && $stable(txt_char_q) && $stable(txt_last_q),
		"pending character changed before it was taken")

endmodule
